@@ design/tidrt_pkg.sv @@
package tidrt_pkg;

   // Default sizes of the table.
   localparam int ID_BITS_DEFAULT    = 16;
   localparam int OWNER_BITS_DEFAULT = 8;
   localparam int STAMP_BITS_DEFAULT = 16;

   // Register reset values.
   localparam logic [3:0]  MAX_ATTEMPTS_RESET   = 4'd10;
   localparam logic [7:0]  SWEEP_INTERVAL_RESET = 8'd12;
   localparam logic [7:0]  EXPIRY_AGE_RESET     = 8'd10;
   localparam logic [15:0] RNG_SEED_RESET       = 16'd44257;

   // Galois LFSR feedback taps.
   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   // Operation codes carried in the request tuser.
   localparam logic [2:0] MODE_ALLOC       = 3'd0;
   localparam logic [2:0] MODE_RELEASE     = 3'd1;
   localparam logic [2:0] MODE_RELEASE_TAG = 3'd2;
   localparam logic [2:0] MODE_LOOKUP      = 3'd3;
   localparam logic [2:0] MODE_TICK        = 3'd4;

   // Status codes carried in the response tuser.
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_ALLOC_FAIL = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MAX_ATTEMPTS   = 2'd0;
   localparam logic [1:0] CSR_SWEEP_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_EXPIRY_AGE     = 2'd2;
   localparam logic [1:0] CSR_RNG_SEED       = 2'd3;

   // Commands from the sequencer to the candidate generator.
   typedef struct packed {
      logic load;
      logic mix;
      logic step;
   } lfsr_ctl_type;

endpackage

@@ design/tidrt_ram.sv @@
module tidrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/tidrt_cand.sv @@
module tidrt_cand import tidrt_pkg::*; #(
   parameter int ID_BITS = ID_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  lfsr_ctl_type       ctl,
   input  logic [15:0]        seed,
   input  logic [15:0]        mix_value,
   output logic [ID_BITS-1:0] cand_next
);

   logic [15:0]        lfsr_ff;
   logic [15:0]        lfsr_in;
   logic [15:0]        stepped;
   logic [15:0]        mixed;
   logic [15:0]        seed_nz;
   logic [31:0]        wide;
   logic [ID_BITS-1:0] hi_part;
   logic [ID_BITS-1:0] lo_part;
   logic [ID_BITS:0]   sum;
   logic [ID_BITS-1:0] fold;

   assign stepped = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : 16'd0);
   assign mixed   = lfsr_ff ^ mix_value;
   assign seed_nz = (seed != 16'd0) ? seed : 16'd1;

   // The stepped value modulo 2^ID_BITS-1: add the high part onto the low
   // part, fold the carry back in, and map the all-ones result to zero.
   assign wide    = 32'(stepped);
   assign hi_part = ID_BITS'(wide >> ID_BITS);
   assign lo_part = stepped[ID_BITS-1:0];
   assign sum     = {1'b0, lo_part} + {1'b0, hi_part};
   assign fold    = sum[ID_BITS-1:0] + ID_BITS'(sum[ID_BITS]);
   assign cand_next = (fold == {ID_BITS{1'b1}}) ? '0 : fold;

   always_comb begin
      lfsr_in = lfsr_ff;
      if (ctl.load) begin
         lfsr_in = seed_nz;
      end else if (ctl.mix) begin
         lfsr_in = (mixed == 16'd0) ? seed_nz : mixed;
      end else if (ctl.step) begin
         lfsr_in = stepped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= RNG_SEED_RESET;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

   // The generator must never lock up in the all-zero state.
   assert property (@(posedge clock) disable iff (reset) lfsr_ff != 16'd0)
      else $error("candidate LFSR reached zero");

endmodule

@@ design/transaction_id_remap_table_top.sv @@
// Channel  Direction  Handshake                  Payload
// req      in         req_tvalid / req_tready    tdata {handler_tag, id_value}, tuser mode
// rsp      out        rsp_tvalid / rsp_tready    tdata {owner_tag, orig_id, new_id}, tuser status
// csr      in         csr_valid / csr_ready      csr_index, csr_data
//
// Release, a lookup of an out-of-range ID, a tick without sweep and the unused
// modes go from acceptance straight to the response state; a lookup of a
// table entry passes a check state first, for the memory read. An allocation
// runs a probe state and a check state for each attempt, since each attempt is
// one read and one check of the table memory. A release by handler or an
// expiry sweep walks the table memory at one entry per cycle.
// After reset a clearing pass zeroes the table; requests are held off
// meanwhile. A new request is taken while the previous response
// still waits in the output register; a stalled response only holds the
// sequencer when its next response is ready.
module transaction_id_remap_table_top import tidrt_pkg::*; #(
   parameter int ID_BITS    = ID_BITS_DEFAULT,
   parameter int OWNER_BITS = OWNER_BITS_DEFAULT,
   parameter int STAMP_BITS = STAMP_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] id_value, [23:16] handler_tag
   input  logic [2:0]  req_tuser,   // [2:0] mode
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] new_id, [31:16] orig_id, [39:32] owner_tag
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   // Table entry layout, from the lowest bit: valid, original ID, owner tag,
   // issue stamp. A cleared entry is the all-zero word.
   localparam int ORIG_LSB   = 1;
   localparam int OWNER_LSB  = ORIG_LSB + 16;
   localparam int STAMP_LSB  = OWNER_LSB + OWNER_BITS;
   localparam int ENTRY_BITS = STAMP_LSB + STAMP_BITS;
   localparam int DEPTH      = 1 << ID_BITS;

   // Sequencer states.
   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_PROBE    = 4'd2;
   localparam logic [3:0] ST_CHECK    = 4'd3;
   localparam logic [3:0] ST_LOOK_CHK = 4'd4;
   localparam logic [3:0] ST_WALK     = 4'd5;
   localparam logic [3:0] ST_WALK_END = 4'd6;
   localparam logic [3:0] ST_RESP     = 4'd7;

   // Control state.
   logic [3:0]            state_ff, state_in;
   logic [ID_BITS-1:0]    walk_addr_ff, walk_addr_in;
   logic                  pend_ff, pend_in;
   logic [3:0]            attempt_ff, attempt_in;
   logic [STAMP_BITS-1:0] now_ff, now_in;
   logic [STAMP_BITS-1:0] last_sweep_ff, last_sweep_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Configuration registers.
   logic [3:0]  max_attempts_ff;
   logic [7:0]  sweep_interval_ff;
   logic [7:0]  expiry_age_ff;
   logic [15:0] rng_seed_ff;

   // Payload registers of the operation in progress.
   logic [ID_BITS-1:0]    pend_addr_ff, pend_addr_in;
   logic [ID_BITS-1:0]    cand_ff, cand_in;
   logic [15:0]           orig_ff, orig_in;
   logic [OWNER_BITS-1:0] tag_ff, tag_in;
   logic                  walk_kind_ff, walk_kind_in;   // 1: by owner, 0: by age
   logic [1:0]            res_status_ff, res_status_in;
   logic [15:0]           res_new_id_ff, res_new_id_in;
   logic [15:0]           res_orig_ff, res_orig_in;
   logic [7:0]            res_owner_ff, res_owner_in;

   // Output register.
   logic [1:0]  rsp_status_ff;
   logic [15:0] rsp_new_id_ff;
   logic [15:0] rsp_orig_ff;
   logic [7:0]  rsp_owner_ff;
   logic        rsp_load;

   // Table memory ports.
   logic                  ram_wr_en;
   logic [ID_BITS-1:0]    ram_wr_addr;
   logic [ENTRY_BITS-1:0] ram_wr_data;
   logic [ID_BITS-1:0]    ram_rd_addr;
   logic [ENTRY_BITS-1:0] ram_rd_data;

   // Candidate generator.
   lfsr_ctl_type       lfsr_ctl;
   logic [15:0]        seed_src;
   logic [ID_BITS-1:0] cand_next;

   // Request decode.
   logic [2:0]         req_mode;
   logic [15:0]        req_id;
   logic [7:0]         req_tag;
   logic               req_in_range;
   logic [ID_BITS-1:0] req_idx;
   logic               req_accept;
   logic               csr_write;

   // Entry decode.
   logic                  ent_valid;
   logic [15:0]           ent_orig;
   logic [OWNER_BITS-1:0] ent_owner;
   logic [STAMP_BITS-1:0] ent_stamp;
   logic [STAMP_BITS-1:0] ent_age;
   logic                  walk_hit;

   // Tick arithmetic.
   logic [STAMP_BITS-1:0] now_tick;
   logic [STAMP_BITS-1:0] since_sweep;
   logic                  sweep_due;

   assign req_mode     = req_tuser;
   assign req_id       = req_tdata[15:0];
   assign req_tag      = req_tdata[23:16];
   assign req_in_range = (32'(req_id) >> ID_BITS) == 32'd0;
   assign req_idx      = ID_BITS'(req_id);
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_accept   = req_tvalid && req_tready;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign ent_valid = ram_rd_data[0];
   assign ent_orig  = ram_rd_data[ORIG_LSB +: 16];
   assign ent_owner = ram_rd_data[OWNER_LSB +: OWNER_BITS];
   assign ent_stamp = ram_rd_data[STAMP_LSB +: STAMP_BITS];
   assign ent_age   = now_ff - ent_stamp;

   // During a walk an entry is freed when it is live and either carries the
   // requested owner tag or has outlived the expiry age.
   assign walk_hit = ent_valid &&
                     (walk_kind_ff ? (ent_owner == tag_ff)
                                   : (ent_age > STAMP_BITS'(expiry_age_ff)));

   assign now_tick    = now_ff + STAMP_BITS'(1);
   assign since_sweep = now_tick - last_sweep_ff;
   assign sweep_due   = since_sweep >= STAMP_BITS'(sweep_interval_ff);

   // A seed write reloads the generator with the new seed; otherwise the
   // stored seed is the fallback when mixing would zero the generator.
   assign seed_src = (csr_write && (csr_index == CSR_RNG_SEED)) ? csr_data : rng_seed_ff;

   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      walk_addr_in  = walk_addr_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      attempt_in    = attempt_ff;
      now_in        = now_ff;
      last_sweep_in = last_sweep_ff;
      cand_in       = cand_ff;
      orig_in       = orig_ff;
      tag_in        = tag_ff;
      walk_kind_in  = walk_kind_ff;
      res_status_in = res_status_ff;
      res_new_id_in = res_new_id_ff;
      res_orig_in   = res_orig_ff;
      res_owner_in  = res_owner_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = pend_addr_ff;
      ram_wr_data = '0;
      ram_rd_addr = req_idx;

      lfsr_ctl      = '0;
      lfsr_ctl.load = csr_write && (csr_index == CSR_RNG_SEED);

      case (state_ff)
         ST_CLEAR: begin
            // Zero one entry per cycle so every valid bit starts cleared.
            ram_wr_en    = 1'b1;
            ram_wr_addr  = walk_addr_ff;
            walk_addr_in = walk_addr_ff + ID_BITS'(1);
            if (walk_addr_ff == {ID_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               res_status_in = STATUS_OK;
               res_new_id_in = 16'd0;
               res_orig_in   = 16'd0;
               res_owner_in  = 8'd0;
               state_in      = ST_RESP;
               case (req_mode)
                  MODE_ALLOC: begin
                     orig_in      = req_id;
                     tag_in       = OWNER_BITS'(req_tag);
                     attempt_in   = 4'd0;
                     lfsr_ctl.mix = 1'b1;
                     if (max_attempts_ff == 4'd0) begin
                        res_status_in = STATUS_ALLOC_FAIL;
                     end else begin
                        state_in = ST_PROBE;
                     end
                  end
                  MODE_RELEASE: begin
                     ram_wr_addr = req_idx;
                     ram_wr_en   = req_in_range;
                  end
                  MODE_RELEASE_TAG: begin
                     tag_in       = OWNER_BITS'(req_tag);
                     walk_kind_in = 1'b1;
                     walk_addr_in = '0;
                     pend_in      = 1'b0;
                     state_in     = ST_WALK;
                  end
                  MODE_LOOKUP: begin
                     // The entry read is already on its way from the address
                     // taken straight off the request.
                     if (req_in_range) begin
                        state_in = ST_LOOK_CHK;
                     end else begin
                        res_status_in = STATUS_NOT_FOUND;
                     end
                  end
                  MODE_TICK: begin
                     now_in = now_tick;
                     if (sweep_due) begin
                        last_sweep_in = now_tick;
                        walk_kind_in  = 1'b0;
                        walk_addr_in  = '0;
                        pend_in       = 1'b0;
                        state_in      = ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_PROBE: begin
            // Step the generator and read the candidate entry.
            lfsr_ctl.step = 1'b1;
            ram_rd_addr   = cand_next;
            cand_in       = cand_next;
            attempt_in    = attempt_ff + 4'd1;
            state_in      = ST_CHECK;
         end

         ST_CHECK: begin
            if ((cand_ff != '0) && !ent_valid) begin
               ram_wr_en     = 1'b1;
               ram_wr_addr   = cand_ff;
               ram_wr_data   = {now_ff, tag_ff, orig_ff, 1'b1};
               res_new_id_in = 16'(cand_ff);
               state_in      = ST_RESP;
            end else if (attempt_ff == max_attempts_ff) begin
               res_status_in = STATUS_ALLOC_FAIL;
               state_in      = ST_RESP;
            end else begin
               state_in = ST_PROBE;
            end
         end

         ST_LOOK_CHK: begin
            if (ent_valid) begin
               res_orig_in  = ent_orig;
               res_owner_in = 8'(ent_owner);
            end else begin
               res_status_in = STATUS_NOT_FOUND;
            end
            state_in = ST_RESP;
         end

         ST_WALK: begin
            // Read the next entry while the previous one is checked and, if
            // it matches, written back cleared.
            ram_rd_addr  = walk_addr_ff;
            pend_addr_in = walk_addr_ff;
            pend_in      = 1'b1;
            walk_addr_in = walk_addr_ff + ID_BITS'(1);
            ram_wr_en    = pend_ff && walk_hit;
            if (walk_addr_ff == {ID_BITS{1'b1}}) begin
               state_in = ST_WALK_END;
            end
         end

         ST_WALK_END: begin
            ram_wr_en = pend_ff && walk_hit;
            pend_in   = 1'b0;
            state_in  = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_CLEAR;
         walk_addr_ff      <= '0;
         pend_ff           <= 1'b0;
         attempt_ff        <= 4'd0;
         now_ff            <= '0;
         last_sweep_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
         max_attempts_ff   <= MAX_ATTEMPTS_RESET;
         sweep_interval_ff <= SWEEP_INTERVAL_RESET;
         expiry_age_ff     <= EXPIRY_AGE_RESET;
         rng_seed_ff       <= RNG_SEED_RESET;
      end else begin
         state_ff      <= state_in;
         walk_addr_ff  <= walk_addr_in;
         pend_ff       <= pend_in;
         attempt_ff    <= attempt_in;
         now_ff        <= now_in;
         last_sweep_ff <= last_sweep_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_MAX_ATTEMPTS:   max_attempts_ff   <= csr_data[3:0];
               CSR_SWEEP_INTERVAL: sweep_interval_ff <= csr_data[7:0];
               CSR_EXPIRY_AGE:     expiry_age_ff     <= csr_data[7:0];
               CSR_RNG_SEED:       rng_seed_ff       <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff  <= pend_addr_in;
      cand_ff       <= cand_in;
      orig_ff       <= orig_in;
      tag_ff        <= tag_in;
      walk_kind_ff  <= walk_kind_in;
      res_status_ff <= res_status_in;
      res_new_id_ff <= res_new_id_in;
      res_orig_ff   <= res_orig_in;
      res_owner_ff  <= res_owner_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_new_id_ff <= res_new_id_ff;
         rsp_orig_ff   <= res_orig_ff;
         rsp_owner_ff  <= res_owner_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_owner_ff, rsp_orig_ff, rsp_new_id_ff};
   assign rsp_tuser  = rsp_status_ff;

   tidrt_cand #(
      .ID_BITS (ID_BITS)
   ) u_cand (
      .clock     (clock),
      .reset     (reset),
      .ctl       (lfsr_ctl),
      .seed      (seed_src),
      .mix_value (req_id),
      .cand_next (cand_next)
   );

   tidrt_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // An allocation check always follows at least one attempt and never more
   // than the configured number.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (attempt_ff != 4'd0) && (attempt_ff <= max_attempts_ff))
      else $error("allocation attempt count out of bounds");

   // A failed allocation never reports a substitute ID.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STATUS_ALLOC_FAIL)) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("failed allocation carries a nonzero ID");

   // A walk writes back exactly the entry it read in the previous cycle.
   assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ((state_ff == ST_WALK) || (state_ff == ST_WALK_END)))
         |-> (ram_wr_addr == $past(ram_rd_addr)))
      else $error("walk write-back address does not match the entry read");

   // Nothing is accepted until the clearing pass has finished.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready && !rsp_tvalid)
      else $error("request or response during the clearing pass");

endmodule

@@ sim/transaction_id_remap_table_top_test.sv @@
module transaction_id_remap_table_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tidrt_pkg::*;

   // Table geometry at the default parameters. Candidates are taken modulo
   // ID_SPAN, so the last table index can never be handed out.
   localparam int TABLE_DEPTH = 1 << ID_BITS_DEFAULT;
   localparam int ID_SPAN     = TABLE_DEPTH - 1;

   // The package names only the five used operations; the rest of the mode
   // space must act as a no-op that still answers with status OK.
   localparam logic [2:0] MODE_SPARE_LOW  = 3'd5;
   localparam logic [2:0] MODE_SPARE_HIGH = 3'd7;

   // A full table walk (clearing pass, sweep or release by owner) accepts
   // nothing while it runs. The limit covers such a walk several times.
   localparam int STALL_LIMIT   = 300000;
   localparam int PHASE_ITEMS   = 320;
   localparam int QUIET_TAIL    = 150;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] id_value;
      logic [7:0]  tag;
   } remap_request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] new_id;
      logic [15:0] orig_id;
      logic [7:0]  owner;
   } remap_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [15:0] id_value, [23:16] handler_tag
   logic [2:0]  req_tuser = '0;   // [2:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [15:0] new_id, [31:16] orig_id, [39:32] owner_tag
   logic [1:0]  rsp_tuser;        // [1:0] status
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   transaction_id_remap_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the remap table. It is updated in acceptance order, so
   // it always matches what the block should hold after the transactions
   // seen so far. Data fields are only read behind a set live bit.
   // ------------------------------------------------------------------
   bit          entry_live  [TABLE_DEPTH];
   bit [15:0]   entry_orig  [TABLE_DEPTH];
   bit [7:0]    entry_owner [TABLE_DEPTH];
   bit [15:0]   entry_stamp [TABLE_DEPTH];
   bit [15:0]   now_sec = '0;
   bit [15:0]   last_sweep_sec = '0;
   bit [15:0]   lfsr_state = RNG_SEED_RESET;
   bit [3:0]    cfg_attempts = MAX_ATTEMPTS_RESET;
   bit [7:0]    cfg_interval = SWEEP_INTERVAL_RESET;
   bit [7:0]    cfg_expiry = EXPIRY_AGE_RESET;
   bit [15:0]   cfg_seed = RNG_SEED_RESET;

   // Substitute IDs handed out recently; release and lookup traffic draws on
   // these so that most of it hits live (or freshly freed) entries.
   logic [15:0]       issued_ids[$];
   remap_request_type queued_requests[$];
   remap_outcome_type pending_outcomes[$];

   int  pushed_count = 0;
   int  accepted_count = 0;
   int  mismatch_count = 0;
   int  quiet_cycles = 0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   // Seconds since the last sweep, as the generator will have them once every
   // queued transaction is accepted. Used to know which tick starts a sweep.
   int  gen_ticks = 0;
   bit  idle_enabled = 1'b1;
   bit  tail_quiet = 1'b0;

   function automatic bit [15:0] lfsr_next(bit [15:0] v);
      return v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
   endfunction

   function automatic bit [15:0] seed_or_one(bit [15:0] s);
      return (s != 16'd0) ? s : 16'd1;
   endfunction

   function automatic void apply_config(logic [1:0] reg_index, logic [15:0] value);
      case (reg_index)
         CSR_MAX_ATTEMPTS:   cfg_attempts = value[3:0];
         CSR_SWEEP_INTERVAL: cfg_interval = value[7:0];
         CSR_EXPIRY_AGE:     cfg_expiry = value[7:0];
         CSR_RNG_SEED: begin
            // A seed write also restarts the candidate generator at once.
            cfg_seed = value;
            lfsr_state = seed_or_one(value);
         end
         default: ;
      endcase
   endfunction

   // Works out the response to one request and advances the shadow table.
   function automatic remap_outcome_type table_outcome(remap_request_type rq);
      remap_outcome_type outcome;
      bit [15:0] cand;
      bit        found;
      outcome = '0;
      found = 1'b0;
      case (rq.mode)
         MODE_ALLOC: begin
            // The original ID is mixed into the generator first; a result of
            // zero would lock the LFSR, so the seed is reloaded instead.
            lfsr_state = lfsr_state ^ rq.id_value;
            if (lfsr_state == 16'd0)
               lfsr_state = seed_or_one(cfg_seed);
            for (int k = 0; k < cfg_attempts; k++) begin
               if (!found) begin
                  lfsr_state = lfsr_next(lfsr_state);
                  cand = 16'(lfsr_state % ID_SPAN);
                  if (cand != 16'd0 && !entry_live[cand]) begin
                     found = 1'b1;
                     entry_live[cand] = 1'b1;
                     entry_orig[cand] = rq.id_value;
                     entry_owner[cand] = rq.tag;
                     entry_stamp[cand] = now_sec;
                     outcome.new_id = cand;
                  end
               end
            end
            if (found) begin
               issued_ids.insert(issued_ids.size(), outcome.new_id);
               if (issued_ids.size() > 256)
                  void'(issued_ids.pop_front());
            end else begin
               outcome.status = STATUS_ALLOC_FAIL;
            end
         end
         MODE_RELEASE: entry_live[rq.id_value] = 1'b0;
         MODE_RELEASE_TAG: begin
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (entry_live[i] && entry_owner[i] == rq.tag)
                  entry_live[i] = 1'b0;
         end
         MODE_LOOKUP: begin
            if (entry_live[rq.id_value]) begin
               outcome.orig_id = entry_orig[rq.id_value];
               outcome.owner = entry_owner[rq.id_value];
            end else begin
               outcome.status = STATUS_NOT_FOUND;
            end
         end
         MODE_TICK: begin
            now_sec = now_sec + 16'd1;
            if (16'(now_sec - last_sweep_sec) >= cfg_interval) begin
               for (int i = 0; i < TABLE_DEPTH; i++)
                  if (entry_live[i] && 16'(now_sec - entry_stamp[i]) > cfg_expiry)
                     entry_live[i] = 1'b0;
               last_sweep_sec = now_sec;
            end
         end
         default: ;
      endcase
      return outcome;
   endfunction

   task automatic flag_mismatch(string what);
      mismatch_count++;
      $display("%0t ns: %s", $realtime, what);
   endtask

   // ------------------------------------------------------------------
   // Driver. The request side takes the next queued transaction once the
   // current one is accepted, with occasional bursts of idle cycles. The
   // response side stalls in bursts of its own. Both are switched off for
   // the tail of the run.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      remap_request_type next_rq;
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (queued_requests.size() > 0) begin
               next_rq = queued_requests.pop_front();
               req_tdata <= {next_rq.tag, next_rq.id_value};
               req_tuser <= next_rq.mode;
               req_tvalid <= 1'b1;
               if (idle_enabled && $urandom_range(0, 5) == 0)
                  req_gap = $urandom_range(1, 15);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_enabled && $urandom_range(0, 6) == 0)
               rsp_gap = $urandom_range(1, 15);
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor. Every accepted request runs through the shadow table and its
   // expected response is queued; every accepted response is checked field
   // by field against the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      remap_request_type seen;
      remap_outcome_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen.mode = req_tuser;
            seen.id_value = req_tdata[15:0];
            seen.tag = req_tdata[23:16];
            pending_outcomes.insert(pending_outcomes.size(), table_outcome(seen));
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               flag_mismatch("response transaction with no request outstanding");
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_tuser !== want.status)
                  flag_mismatch($sformatf("status: got %0d, expected %0d",
                                          rsp_tuser, want.status));
               if (rsp_tdata[15:0] !== want.new_id)
                  flag_mismatch($sformatf("new_id: got %h, expected %h",
                                          rsp_tdata[15:0], want.new_id));
               if (rsp_tdata[31:16] !== want.orig_id)
                  flag_mismatch($sformatf("orig_id: got %h, expected %h",
                                          rsp_tdata[31:16], want.orig_id));
               if (rsp_tdata[39:32] !== want.owner)
                  flag_mismatch($sformatf("owner_tag: got %h, expected %h",
                                          rsp_tdata[39:32], want.owner));
            end
         end
      end
   end

   // Watchdog: a run of cycles in which no channel moves a transaction means
   // the block has hung.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("transaction_id_remap_table_top test failed");
            $finish;
         end
      end
   end

   // Queues one request, keeping only a few ahead of the driver so that the
   // issued-ID list stays close to the live table contents.
   task automatic push_request(logic [2:0] mode, logic [15:0] id_value, logic [7:0] tag);
      remap_request_type rq;
      while (queued_requests.size() >= 4)
         @(posedge clock);
      rq.mode = mode;
      rq.id_value = id_value;
      rq.tag = tag;
      if (mode == MODE_TICK) begin
         gen_ticks++;
         if (gen_ticks >= cfg_interval)
            gen_ticks = 0;
      end
      queued_requests.insert(queued_requests.size(), rq);
      pushed_count++;
   endtask

   // Holds the sender until every queued request is accepted and every
   // expected response has come back, then lets the block go quiet.
   task automatic settle();
      while (accepted_count != pushed_count || pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] reg_index, logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      apply_config(reg_index, value);
      csr_valid <= 1'b0;
   endtask

   // Writes all four registers. With scramble set, the bits above each
   // register's width carry noise that the block must ignore.
   task automatic load_settings(logic [3:0] attempts, logic [7:0] interval,
                                logic [7:0] expiry, logic [15:0] seed, bit scramble);
      logic [11:0] noise_hi;
      logic [7:0]  noise_lo;
      noise_hi = scramble ? 12'($urandom) : 12'd0;
      noise_lo = scramble ? 8'($urandom) : 8'd0;
      settle();
      write_register(CSR_MAX_ATTEMPTS, {noise_hi, attempts});
      write_register(CSR_SWEEP_INTERVAL, {noise_lo, interval});
      write_register(CSR_EXPIRY_AGE, {~noise_lo, expiry});
      write_register(CSR_RNG_SEED, seed);
   endtask

   function automatic logic [15:0] pick_table_id();
      if (issued_ids.size() > 0 && $urandom_range(0, 3) != 0)
         return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
      return 16'($urandom);
   endfunction

   // Directed walk through the table operations: extremes of the IDs and
   // tags, lookups of live, freed and never-allocatable entries, release of
   // a free entry, release by owner, the spare modes and an expiry sweep.
   task automatic run_table_basics();
      logic [15:0] first_id, second_id, third_id;
      write_register(CSR_SWEEP_INTERVAL, 16'd3);
      write_register(CSR_EXPIRY_AGE, 16'd1);
      push_request(MODE_ALLOC, 16'h0000, 8'h00);
      push_request(MODE_ALLOC, 16'hFFFF, 8'hFF);
      push_request(MODE_ALLOC, 16'h1234, 8'h5A);
      settle();
      first_id = issued_ids[0];
      second_id = issued_ids[1];
      third_id = issued_ids[2];
      push_request(MODE_LOOKUP, first_id, 8'h00);
      push_request(MODE_LOOKUP, second_id, 8'h00);
      // Index zero and the top index are never handed out.
      push_request(MODE_LOOKUP, 16'h0000, 8'hFF);
      push_request(MODE_LOOKUP, 16'hFFFF, 8'h00);
      push_request(MODE_RELEASE, first_id, 8'h00);
      push_request(MODE_LOOKUP, first_id, 8'h00);
      // Releasing an entry that is already free still answers OK.
      push_request(MODE_RELEASE, first_id, 8'hFF);
      push_request(MODE_RELEASE_TAG, 16'hFFFF, 8'hFF);
      push_request(MODE_LOOKUP, second_id, 8'h00);
      push_request(MODE_LOOKUP, third_id, 8'h00);
      push_request(MODE_SPARE_LOW, 16'hFFFF, 8'hFF);
      push_request(MODE_SPARE_HIGH, 16'h0000, 8'h00);
      // With a three-second sweep interval the third tick sweeps, and the
      // remaining entry is three seconds old, past the one-second age.
      push_request(MODE_TICK, 16'h0000, 8'h00);
      push_request(MODE_TICK, 16'hFFFF, 8'hFF);
      push_request(MODE_TICK, 16'h0000, 8'h00);
      push_request(MODE_LOOKUP, third_id, 8'h00);
      settle();
   endtask

   // Directed cases around the candidate generator.
   task automatic run_generator_cases();
      write_register(CSR_MAX_ATTEMPTS, 16'd1);
      // 0x97FF steps to 0xFFFF, whose candidate is zero: a failed attempt.
      write_register(CSR_RNG_SEED, 16'h97FF);
      push_request(MODE_ALLOC, 16'h0000, 8'h11);
      settle();
      // Mixing an original ID equal to the LFSR value zeroes it, so the
      // seed is reloaded. Reseeding and repeating then hits the same,
      // now occupied, candidate.
      write_register(CSR_RNG_SEED, 16'h1357);
      push_request(MODE_ALLOC, 16'h1357, 8'h22);
      settle();
      write_register(CSR_RNG_SEED, 16'h1357);
      push_request(MODE_ALLOC, 16'h1357, 8'h22);
      settle();
      // A second attempt moves past the occupied candidate.
      write_register(CSR_MAX_ATTEMPTS, 16'd2);
      write_register(CSR_RNG_SEED, 16'h1357);
      push_request(MODE_ALLOC, 16'h1357, 8'h33);
      settle();
      // A zero seed loads the LFSR with one; mixing in one then zeroes it
      // and the reload must again fall back to one.
      write_register(CSR_RNG_SEED, 16'h0000);
      push_request(MODE_ALLOC, 16'h0001, 8'h44);
      settle();
      // With no attempts allowed every allocation fails.
      write_register(CSR_MAX_ATTEMPTS, 16'd0);
      push_request(MODE_ALLOC, 16'hBEEF, 8'h55);
      settle();
   endtask

   // Random traffic. Each phase may spend one full table walk, either on a
   // release by owner or on a sweeping tick; once it is spent, ticks that
   // would sweep turn into lookups to keep the run short.
   task automatic run_random_phase(int items, bit last_phase);
      int          walks_left;
      int          roll;
      logic [2:0]  mode;
      logic [15:0] id_value;
      logic [7:0]  tag;
      walks_left = 1;
      for (int n = 0; n < items; n++) begin
         if (last_phase && n == items - QUIET_TAIL) begin
            tail_quiet = 1'b1;
            idle_enabled = 1'b0;
         end else if (!tail_quiet && $urandom_range(0, 79) == 0) begin
            idle_enabled = !idle_enabled;
         end
         if (!tail_quiet && $urandom_range(0, 199) == 0)
            settle();
         roll = $urandom_range(0, 99);
         // Tags cluster on a few values so that release by owner hits.
         tag = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
         id_value = 16'($urandom);
         if (roll < 36) begin
            mode = MODE_ALLOC;
         end else if (roll < 52) begin
            mode = MODE_RELEASE;
            id_value = pick_table_id();
         end else if (roll < 80) begin
            mode = MODE_LOOKUP;
            id_value = pick_table_id();
         end else if (roll < 96) begin
            mode = MODE_TICK;
            if (gen_ticks + 1 >= cfg_interval) begin
               if (walks_left > 0) begin
                  walks_left--;
               end else begin
                  mode = MODE_LOOKUP;
                  id_value = pick_table_id();
               end
            end
         end else if (roll < 99) begin
            mode = 3'($urandom_range(MODE_SPARE_LOW, MODE_SPARE_HIGH));
         end else if (walks_left > 0) begin
            mode = MODE_RELEASE_TAG;
            walks_left--;
         end else begin
            mode = MODE_LOOKUP;
            id_value = pick_table_id();
         end
         push_request(mode, id_value, tag);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      run_table_basics();
      run_generator_cases();

      // Upper extremes: longest allocation, sweeps that free nothing.
      load_settings(4'd15, 8'd255, 8'd255, 16'($urandom_range(1, 65535)), 1'b0);
      run_random_phase(PHASE_ITEMS, 1'b0);
      // Lower extremes: single attempt, every tick sweeps.
      load_settings(4'd1, 8'd1, 8'd1, 16'd1, 1'b0);
      run_random_phase(PHASE_ITEMS, 1'b0);
      load_settings(4'($urandom_range(1, 15)), 8'($urandom_range(2, 40)),
                    8'($urandom_range(1, 30)), 16'($urandom_range(1, 65535)), 1'b1);
      run_random_phase(PHASE_ITEMS, 1'b0);
      load_settings(4'($urandom_range(1, 15)), 8'($urandom_range(2, 40)),
                    8'($urandom_range(1, 30)), 16'($urandom_range(1, 65535)), 1'b1);
      run_random_phase(PHASE_ITEMS, 1'b0);
      load_settings(MAX_ATTEMPTS_RESET, SWEEP_INTERVAL_RESET, EXPIRY_AGE_RESET,
                    RNG_SEED_RESET, 1'b0);
      run_random_phase(PHASE_ITEMS, 1'b1);

      settle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("transaction_id_remap_table_top test passed");
      else
         $display("transaction_id_remap_table_top test failed");
      $finish;
   end

endmodule

@@ sim.f @@
design/tidrt_pkg.sv
design/tidrt_ram.sv
design/tidrt_cand.sv
design/transaction_id_remap_table_top.sv
sim/transaction_id_remap_table_top_test.sv
